/* sv/psc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psc_pkg: shared types and constants of the PID speed controller
// Field widths, fixed-point formats, register indexes and reset values.
// ----------------------------------------------------------------------------
package psc_pkg;

   // Speed and gain formats
   localparam int SPEED_BITS     = 16;
   localparam int GAIN_FRAC_BITS = 20;
   localparam int GAIN_W         = 24;
   localparam int CORR_W         = 32;

   // Datapath widths
   localparam int ERR_W    = SPEED_BITS + 1;             // target - measured
   localparam int DIFF_W   = SPEED_BITS + 2;             // err - last_error
   localparam int SUM_W    = 40;                         // running error sum
   localparam int SUM_LO_W = SUM_W / 2;                  // low half of the sum split
   localparam int SUM_HI_W = SUM_W - SUM_LO_W;
   localparam int P_W      = GAIN_W + 1 + ERR_W;         // proportional product
   localparam int D_W      = GAIN_W + 1 + DIFF_W;        // derivative product
   localparam int PL_W     = GAIN_W + SUM_LO_W;          // integral low partial
   localparam int PH_W     = GAIN_W + 1 + SUM_HI_W;      // integral high partial
   localparam int ACC_W    = 64;                         // product sum
   localparam int Q_W      = ACC_W - GAIN_FRAC_BITS;     // scaled product sum
   localparam int DRV_W    = CORR_W + 2;                 // target + correction

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] PROD_LIM = ACC_W'(64'sd1 <<< 61);
   localparam logic signed [ACC_W-1:0] TRUNC_BIAS = ACC_W'((64'sd1 <<< GAIN_FRAC_BITS) - 1);
   localparam logic signed [Q_W-1:0] CORR_MAX = Q_W'({1'b0, {(CORR_W-1){1'b1}}});
   localparam logic signed [Q_W-1:0] CORR_MIN = -(Q_W'(64'sd1 <<< (CORR_W-1)));

   // Configuration register file
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = GAIN_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P    = 2'd0,
      CSR_GAIN_I    = 2'd1,
      CSR_GAIN_D    = 2'd2,
      CSR_MAX_SPEED = 2'd3
   } csr_index_type;

   localparam logic [GAIN_W-1:0]     GAIN_P_RESET    = 24'd613417;  // 0.585
   localparam logic [GAIN_W-1:0]     GAIN_I_RESET    = 24'd52;      // 0.00005
   localparam logic [GAIN_W-1:0]     GAIN_D_RESET    = 24'd471859;  // 0.45
   localparam logic [SPEED_BITS-1:0] MAX_SPEED_RESET = 16'd2500;

endpackage
`default_nettype wire

/* sv/pid_speed_controller_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one transaction per cycle unless rsp_stall backs the pipeline
// up to the input; the error state updates at accept.
// The six-stage pipeline is split at the integral product, which is formed
// from two 24x20 partial products, then combined, scaled and clamped.
// Reset: synchronous, clears the pipeline, the error state and loads the
// default gains and speed limit.
// ----------------------------------------------------------------------------
// pid_speed_controller_top: pipelined PID fan speed correction
// Forms error, derivative and saturating integral, weights them with the
// Q4.20 gains, truncates toward zero and clamps the drive speed.
// ----------------------------------------------------------------------------
module pid_speed_controller_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic [psc_pkg::SPEED_BITS-1:0]      req_target_speed,
   input  wire logic [psc_pkg::SPEED_BITS-1:0]      req_measured_speed,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic [psc_pkg::SPEED_BITS-1:0]      rsp_drive_speed,
   output      logic signed [psc_pkg::CORR_W-1:0]   rsp_correction,
   input  wire logic                                csr_write_enable,
   input  wire logic [psc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [psc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int SW = psc_pkg::SPEED_BITS;

   // Configuration registers
   logic [psc_pkg::GAIN_W-1:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [SW-1:0]              max_speed_ff;

   // Error state
   logic signed [psc_pkg::DIFF_W-1:0] last_error_ff;
   logic signed [psc_pkg::SUM_W-1:0]  error_sum_ff;

   // Stage valids and load enables
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic en1, en2, en3, en4, en5, en6;
   logic req_accept;

   // Stage payloads
   logic [SW-1:0] t1_ff, t2_ff, t3_ff, t4_ff, t5_ff, t6_ff;
   logic signed [psc_pkg::ERR_W-1:0]  s1_err_ff;
   logic signed [psc_pkg::DIFF_W-1:0] s1_diff_ff;
   logic signed [psc_pkg::SUM_W-1:0]  s1_sum_ff;
   logic signed [psc_pkg::P_W-1:0]    s2_p_ff;
   logic signed [psc_pkg::D_W-1:0]    s2_d_ff;
   logic [psc_pkg::PL_W-1:0]          s2_pl_ff;
   logic signed [psc_pkg::PH_W-1:0]   s2_ph_ff;
   logic signed [psc_pkg::ACC_W-1:0]  s3_pi_ff, s3_pd_ff;
   logic signed [psc_pkg::ACC_W-1:0]  s4_acc_ff;
   logic signed [psc_pkg::CORR_W-1:0] s5_corr_ff;
   logic [SW-1:0]                     drive_ff;
   logic signed [psc_pkg::CORR_W-1:0] corr_ff;

   // Combinational next values
   logic signed [psc_pkg::ERR_W-1:0]   err_in;
   logic signed [psc_pkg::DIFF_W-1:0]  diff_in;
   logic signed [psc_pkg::SUM_W:0]     sum_raw;
   logic signed [psc_pkg::SUM_W-1:0]   sum_in;
   logic [psc_pkg::SUM_LO_W-1:0]       sum_lo;
   logic signed [psc_pkg::SUM_HI_W-1:0] sum_hi;
   logic signed [psc_pkg::P_W-1:0]     p_in;
   logic signed [psc_pkg::D_W-1:0]     d_in;
   logic [psc_pkg::PL_W-1:0]           pl_in;
   logic signed [psc_pkg::PH_W-1:0]    ph_in;
   logic signed [psc_pkg::ACC_W-1:0]   pi_full, pi_in, pd_in, acc_in, biased;
   logic signed [psc_pkg::Q_W-1:0]     scaled;
   logic signed [psc_pkg::CORR_W-1:0]  corr_in;
   logic signed [psc_pkg::DRV_W-1:0]   drive_sum;
   logic [SW-1:0]                      drive_in;

   // Each stage loads when it is empty or its successor loads
   assign en6 = !v6_ff || !rsp_stall;
   assign en5 = !v5_ff || en6;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_stall  = !en1;
   assign req_accept = req_valid && en1;

   // Stage 1: error, derivative and saturating sum
   always_comb begin
      err_in  = signed'({1'b0, req_target_speed}) - signed'({1'b0, req_measured_speed});
      diff_in = psc_pkg::DIFF_W'(err_in) - last_error_ff;
      sum_raw = (psc_pkg::SUM_W+1)'(error_sum_ff) + (psc_pkg::SUM_W+1)'(err_in);
      if (sum_raw[psc_pkg::SUM_W] != sum_raw[psc_pkg::SUM_W-1]) begin
         sum_in = sum_raw[psc_pkg::SUM_W] ? psc_pkg::SUM_MIN : psc_pkg::SUM_MAX;
      end else begin
         sum_in = sum_raw[psc_pkg::SUM_W-1:0];
      end
   end

   // Stage 2: gain products, integral split into two partial products
   always_comb begin
      sum_lo = s1_sum_ff[psc_pkg::SUM_LO_W-1:0];
      sum_hi = s1_sum_ff[psc_pkg::SUM_W-1:psc_pkg::SUM_LO_W];
      p_in   = signed'({1'b0, gain_p_ff}) * s1_err_ff;
      d_in   = signed'({1'b0, gain_d_ff}) * s1_diff_ff;
      pl_in  = gain_i_ff * sum_lo;
      ph_in  = signed'({1'b0, gain_i_ff}) * sum_hi;
   end

   // Stage 3: combine and limit the integral product, add P and D terms
   always_comb begin
      pi_full = (psc_pkg::ACC_W'(s2_ph_ff) <<< psc_pkg::SUM_LO_W)
              + signed'(psc_pkg::ACC_W'(s2_pl_ff));
      if (pi_full > psc_pkg::PROD_LIM) begin
         pi_in = psc_pkg::PROD_LIM;
      end else if (pi_full < -psc_pkg::PROD_LIM) begin
         pi_in = -psc_pkg::PROD_LIM;
      end else begin
         pi_in = pi_full;
      end
      pd_in = psc_pkg::ACC_W'(s2_p_ff) + psc_pkg::ACC_W'(s2_d_ff);
   end

   // Stage 4: full product sum
   assign acc_in = s3_pi_ff + s3_pd_ff;

   // Stage 5: scale with truncation toward zero, saturate to 32 bits
   always_comb begin
      biased = s4_acc_ff + (s4_acc_ff[psc_pkg::ACC_W-1] ? psc_pkg::TRUNC_BIAS : '0);
      scaled = biased[psc_pkg::ACC_W-1:psc_pkg::GAIN_FRAC_BITS];
      if (scaled > psc_pkg::CORR_MAX) begin
         corr_in = psc_pkg::CORR_MAX[psc_pkg::CORR_W-1:0];
      end else if (scaled < psc_pkg::CORR_MIN) begin
         corr_in = psc_pkg::CORR_MIN[psc_pkg::CORR_W-1:0];
      end else begin
         corr_in = scaled[psc_pkg::CORR_W-1:0];
      end
   end

   // Stage 6: corrected speed clamped to 0..max_speed
   always_comb begin
      drive_sum = signed'(psc_pkg::DRV_W'(t5_ff)) + psc_pkg::DRV_W'(s5_corr_ff);
      if (drive_sum > signed'(psc_pkg::DRV_W'(max_speed_ff))) begin
         drive_in = max_speed_ff;
      end else if (drive_sum < 0) begin
         drive_in = '0;
      end else begin
         drive_in = drive_sum[SW-1:0];
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff    <= psc_pkg::GAIN_P_RESET;
         gain_i_ff    <= psc_pkg::GAIN_I_RESET;
         gain_d_ff    <= psc_pkg::GAIN_D_RESET;
         max_speed_ff <= psc_pkg::MAX_SPEED_RESET;
      end else if (csr_write_enable) begin
         case (psc_pkg::csr_index_type'(csr_index))
            psc_pkg::CSR_GAIN_P:    gain_p_ff    <= csr_wdata;
            psc_pkg::CSR_GAIN_I:    gain_i_ff    <= csr_wdata;
            psc_pkg::CSR_GAIN_D:    gain_d_ff    <= csr_wdata;
            psc_pkg::CSR_MAX_SPEED: max_speed_ff <= csr_wdata[SW-1:0];
            default: ;
         endcase
      end
   end

   // Update the error state on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff <= '0;
         error_sum_ff  <= '0;
      end else if (req_accept) begin
         last_error_ff <= psc_pkg::DIFF_W'(err_in);
         error_sum_ff  <= sum_in;
      end
   end

   // Advance stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
      end
   end

   // Advance stage payloads
   always_ff @(posedge clock) begin
      if (en1) begin
         t1_ff      <= req_target_speed;
         s1_err_ff  <= err_in;
         s1_diff_ff <= diff_in;
         s1_sum_ff  <= sum_in;
      end
      if (en2) begin
         t2_ff    <= t1_ff;
         s2_p_ff  <= p_in;
         s2_d_ff  <= d_in;
         s2_pl_ff <= pl_in;
         s2_ph_ff <= ph_in;
      end
      if (en3) begin
         t3_ff    <= t2_ff;
         s3_pi_ff <= pi_in;
         s3_pd_ff <= pd_in;
      end
      if (en4) begin
         t4_ff     <= t3_ff;
         s4_acc_ff <= acc_in;
      end
      if (en5) begin
         t5_ff      <= t4_ff;
         s5_corr_ff <= corr_in;
      end
      if (en6) begin
         t6_ff    <= t5_ff;
         drive_ff <= drive_in;
         corr_ff  <= s5_corr_ff;
      end
   end

   assign rsp_valid       = v6_ff;
   assign rsp_drive_speed = drive_ff;
   assign rsp_correction  = corr_ff;

   // Drive speed never exceeds the configured limit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_drive_speed <= max_speed_ff)
      else $error("drive speed above max_speed");

   // With no correction the drive speed is the clamped target
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_correction == 0 |->
         rsp_drive_speed == ((t6_ff > max_speed_ff) ? max_speed_ff : t6_ff))
      else $error("drive speed does not follow target");

   // Input stalls only when stage 1 holds a transaction that cannot move
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v1_ff && v2_ff && v3_ff && v4_ff && v5_ff && v6_ff && rsp_stall)
      else $error("input stalled with room in the pipeline");

   // Reset empties the pipeline and clears the error state
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !v1_ff && error_sum_ff == 0 && last_error_ff == 0)
      else $error("state not cleared by reset");

   // The error state changes only on an accepted transaction
   assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(error_sum_ff) && $stable(last_error_ff))
      else $error("error state changed without a transaction");

endmodule
`default_nettype wire

/* tb/tb_pid_speed_controller_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pid_speed_controller_top: self-checking bench of the PID speed controller
// Drives speed samples through the valid/stall request channel, predicts the
// drive speed and correction of each accepted sample with an independent
// fixed-point model of the loop, and compares every response in order. Covers
// default and extreme gains, a zero speed limit, integral windup with
// full-scale gains, back-pressure and randomized closed-loop traffic.
// ----------------------------------------------------------------------------
module tb_pid_speed_controller_top;

   localparam int     WATCHDOG_LIMIT = 4000;
   localparam int     HOLD_CYCLES    = 200;
   localparam int     WINDUP_ITEMS   = 50;
   localparam longint CORR_HI        = 64'sd2147483647;
   localparam longint CORR_LO        = -64'sd2147483648;

   typedef struct {
      logic [psc_pkg::SPEED_BITS-1:0]    drive;
      logic signed [psc_pkg::CORR_W-1:0] corr;
   } speed_cmd_type;

   logic                                    clock = 1'b0;
   logic                                    reset;
   logic                                    req_valid;
   logic                                    req_stall;
   logic [psc_pkg::SPEED_BITS-1:0]          req_target_speed;
   logic [psc_pkg::SPEED_BITS-1:0]          req_measured_speed;
   logic                                    rsp_valid;
   logic                                    rsp_stall;
   logic [psc_pkg::SPEED_BITS-1:0]          rsp_drive_speed;
   logic signed [psc_pkg::CORR_W-1:0]       rsp_correction;
   logic                                    csr_write_enable;
   logic [psc_pkg::CSR_IDX_W-1:0]           csr_index;
   logic [psc_pkg::CSR_DATA_W-1:0]          csr_wdata;

   // Loop model: configuration and error state
   logic [psc_pkg::GAIN_W-1:0]              cfg_gain_p;
   logic [psc_pkg::GAIN_W-1:0]              cfg_gain_i;
   logic [psc_pkg::GAIN_W-1:0]              cfg_gain_d;
   logic [psc_pkg::SPEED_BITS-1:0]          cfg_max_speed;
   logic signed [psc_pkg::DIFF_W-1:0]       loop_last_err;
   logic signed [psc_pkg::SUM_W-1:0]        loop_err_sum;
   logic [psc_pkg::SPEED_BITS-1:0]          last_drive;

   speed_cmd_type                  expected_cmds[$];
   int                             error_count = 0;
   int                             quiet_cycles = 0;
   bit                             req_idle_on = 1'b0;
   logic                           rsp_idle_on;
   logic                           rsp_hold;
   int                             rsp_burst_left = 0;

   pid_speed_controller_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_target_speed   (req_target_speed),
      .req_measured_speed (req_measured_speed),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_drive_speed    (rsp_drive_speed),
      .rsp_correction     (rsp_correction),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Advance the loop state by one sample and return the expected response
   function automatic speed_cmd_type predict_speed_cmd(
         input logic [psc_pkg::SPEED_BITS-1:0] tgt,
         input logic [psc_pkg::SPEED_BITS-1:0] meas);
      speed_cmd_type cmd;
      longint      err;
      longint      diff;
      longint      err_sum_next;
      longint      i_term;
      longint      acc;
      longint      scaled;
      longint      total;
      logic [63:0] mag;
      err = longint'(tgt) - longint'(meas);
      diff = err - longint'(loop_last_err);
      err_sum_next = longint'(loop_err_sum) + err;
      if (err_sum_next > longint'(psc_pkg::SUM_MAX)) err_sum_next = longint'(psc_pkg::SUM_MAX);
      if (err_sum_next < longint'(psc_pkg::SUM_MIN)) err_sum_next = longint'(psc_pkg::SUM_MIN);

      // Limit the integral product, then add the three weighted terms exactly
      i_term = longint'(cfg_gain_i) * err_sum_next;
      if (i_term > longint'(psc_pkg::PROD_LIM)) i_term = longint'(psc_pkg::PROD_LIM);
      if (i_term < -longint'(psc_pkg::PROD_LIM)) i_term = -longint'(psc_pkg::PROD_LIM);
      acc = longint'(cfg_gain_p) * err + i_term + longint'(cfg_gain_d) * diff;

      // Drop the gain fraction, rounding toward zero
      if (acc < 0) begin
         mag = -acc;
         mag = mag >> psc_pkg::GAIN_FRAC_BITS;
         scaled = -longint'(mag);
      end else begin
         scaled = acc >>> psc_pkg::GAIN_FRAC_BITS;
      end
      if (scaled > CORR_HI) scaled = CORR_HI;
      if (scaled < CORR_LO) scaled = CORR_LO;

      total = longint'(tgt) + scaled;
      if (total > longint'(cfg_max_speed)) total = longint'(cfg_max_speed);
      if (total < 0) total = 0;

      loop_err_sum = psc_pkg::SUM_W'(err_sum_next);
      loop_last_err = psc_pkg::DIFF_W'(err);
      cmd.drive = psc_pkg::SPEED_BITS'(total);
      cmd.corr = psc_pkg::CORR_W'(scaled);
      return cmd;
   endfunction

   // Offer one speed sample, wait for acceptance and record its expected response
   task automatic send_sample(input logic [psc_pkg::SPEED_BITS-1:0] tgt,
                              input logic [psc_pkg::SPEED_BITS-1:0] meas);
      speed_cmd_type cmd;
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_target_speed <= tgt;
      req_measured_speed <= meas;
      do @(posedge clock); while (req_stall);
      cmd = predict_speed_cmd(tgt, meas);
      last_drive = cmd.drive;
      expected_cmds.push_back(cmd);
   endtask

   // Drop the request and hold until every outstanding response is back
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (expected_cmds.size() != 0) @(posedge clock);
   endtask

   // Write one register; only called while the pipeline is empty
   task automatic write_csr(input psc_pkg::csr_index_type idx,
                            input logic [psc_pkg::CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         psc_pkg::CSR_GAIN_P:    cfg_gain_p = value;
         psc_pkg::CSR_GAIN_I:    cfg_gain_i = value;
         psc_pkg::CSR_GAIN_D:    cfg_gain_d = value;
         psc_pkg::CSR_MAX_SPEED: cfg_max_speed = value[psc_pkg::SPEED_BITS-1:0];
         default: ;
      endcase
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [psc_pkg::GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return '1;
         2:       return psc_pkg::GAIN_W'($urandom_range(0, 24'h200000));
         default: return psc_pkg::GAIN_W'($urandom);
      endcase
   endfunction

   // Receiver: random stall bursts, or a long hold when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_burst_left = 0;
      end else if (rsp_hold) begin
         rsp_stall <= 1'b1;
      end else if (!rsp_idle_on) begin
         rsp_stall <= 1'b0;
         rsp_burst_left = 0;
      end else if (rsp_burst_left > 0) begin
         rsp_stall <= 1'b1;
         rsp_burst_left--;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         rsp_burst_left = $urandom_range(0, 11);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each accepted response with the oldest expectation
   always @(posedge clock) begin
      speed_cmd_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_cmds.size() == 0) begin
            $display("%0t: response with no pending sample, drive %0d correction %0d",
                     $time, rsp_drive_speed, rsp_correction);
            error_count++;
         end else begin
            want = expected_cmds.pop_front();
            if (rsp_drive_speed !== want.drive) begin
               $display("%0t: drive_speed mismatch, expected %0d, actual %0d",
                        $time, want.drive, rsp_drive_speed);
               error_count++;
            end
            if (rsp_correction !== want.corr) begin
               $display("%0t: correction mismatch, expected %0d, actual %0d",
                        $time, want.corr, rsp_correction);
               error_count++;
            end
         end
      end
   end

   // Watchdog: end the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles at %0t", quiet_cycles, $time);
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Default gains and limit straight out of reset, at the field extremes
   task automatic test_reset_defaults();
      send_sample(16'd0, 16'd0);
      send_sample(16'd65535, 16'd0);
      send_sample(16'd0, 16'd65535);
      send_sample(16'd65535, 16'd65535);
      send_sample(16'd2500, 16'd2400);
      send_sample(16'd1200, 16'd2600);
      send_sample(16'd2400, 16'd2500);
      send_sample(16'd1, 16'd0);
      drain_responses();
   endtask

   // Full-scale and zero gains, with full-swing derivative steps
   task automatic test_gain_extremes();
      write_csr(psc_pkg::CSR_GAIN_P, '1);
      write_csr(psc_pkg::CSR_GAIN_I, '1);
      write_csr(psc_pkg::CSR_GAIN_D, '1);
      write_csr(psc_pkg::CSR_MAX_SPEED, 24'd65535);
      send_sample(16'd65535, 16'd0);
      send_sample(16'd0, 16'd65535);
      send_sample(16'd30000, 16'd30001);
      send_sample(16'd40000, 16'd39000);
      drain_responses();
      write_csr(psc_pkg::CSR_GAIN_P, '0);
      write_csr(psc_pkg::CSR_GAIN_I, '0);
      write_csr(psc_pkg::CSR_GAIN_D, '0);
      send_sample(16'd12345, 16'd54321);
      send_sample(16'd65535, 16'd0);
      send_sample(16'd0, 16'd0);
      drain_responses();
   endtask

   // Zero speed limit pins the drive at 0; upper write bits of the limit are dropped
   task automatic test_speed_limit();
      write_csr(psc_pkg::CSR_GAIN_P, psc_pkg::GAIN_P_RESET);
      write_csr(psc_pkg::CSR_GAIN_I, psc_pkg::GAIN_I_RESET);
      write_csr(psc_pkg::CSR_GAIN_D, psc_pkg::GAIN_D_RESET);
      write_csr(psc_pkg::CSR_MAX_SPEED, 24'd0);
      send_sample(16'd3000, 16'd1000);
      send_sample(16'd65535, 16'd0);
      send_sample(16'd0, 16'd500);
      drain_responses();
      write_csr(psc_pkg::CSR_MAX_SPEED, 24'hABCDEF);
      send_sample(16'd60000, 16'd20000);
      send_sample(16'd52000, 16'd52700);
      drain_responses();
   endtask

   // Wind the integral up, down past zero and back with full-scale gains
   task automatic test_integral_windup();
      write_csr(psc_pkg::CSR_GAIN_P, '1);
      write_csr(psc_pkg::CSR_GAIN_I, '1);
      write_csr(psc_pkg::CSR_GAIN_D, '1);
      write_csr(psc_pkg::CSR_MAX_SPEED, 24'd65535);
      repeat (WINDUP_ITEMS) send_sample(16'd65535, 16'd0);
      repeat (2 * WINDUP_ITEMS) send_sample(16'd0, 16'd65535);
      repeat (WINDUP_ITEMS) send_sample(16'd65535, 16'd0);
      drain_responses();
   endtask

   // Hold the response side long enough to fill the pipeline and stall requests
   task automatic test_backpressure();
      req_idle_on = 1'b0;
      rsp_hold <= 1'b1;
      fork
         begin
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      repeat (40) send_sample(16'($urandom), 16'($urandom));
      drain_responses();
   endtask

   // Mostly closed-loop samples around a held target, plus noise and extremes
   task automatic run_traffic(input int n_items);
      logic [psc_pkg::SPEED_BITS-1:0] loop_target;
      logic [psc_pkg::SPEED_BITS-1:0] tgt;
      logic [psc_pkg::SPEED_BITS-1:0] meas;
      int                    pick;
      int                    m;
      loop_target = 16'($urandom_range(0, 4000));
      for (int n = 0; n < n_items; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            if ($urandom_range(0, 15) == 0) loop_target = 16'($urandom);
            m = int'(last_drive) + $urandom_range(0, 64) - 32;
            if (m < 0) m = 0;
            if (m > 65535) m = 65535;
            tgt = loop_target;
            meas = 16'(m);
         end else if (pick < 85) begin
            tgt = 16'($urandom);
            meas = 16'($urandom);
         end else begin
            tgt = ($urandom_range(0, 1) == 0) ? '0 : '1;
            meas = ($urandom_range(0, 2) == 0) ? 16'($urandom) :
                   (($urandom_range(0, 1) == 0) ? '0 : '1);
         end
         send_sample(tgt, meas);
      end
   endtask

   // Several random configurations, then a final stretch with no idling
   task automatic test_random_traffic();
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(psc_pkg::CSR_GAIN_P, pick_gain());
         write_csr(psc_pkg::CSR_GAIN_I, pick_gain());
         write_csr(psc_pkg::CSR_GAIN_D, pick_gain());
         case ($urandom_range(0, 3))
            0:       write_csr(psc_pkg::CSR_MAX_SPEED, 24'd65535);
            1:       write_csr(psc_pkg::CSR_MAX_SPEED, 24'($urandom_range(0, 8000)));
            default: write_csr(psc_pkg::CSR_MAX_SPEED, 24'($urandom));
         endcase
         req_idle_on = (ph != 3);
         rsp_idle_on <= (ph != 2);
         run_traffic(50);
         drain_responses();
      end
      req_idle_on = 1'b0;
      rsp_idle_on <= 1'b0;
      write_csr(psc_pkg::CSR_GAIN_P, psc_pkg::GAIN_P_RESET);
      write_csr(psc_pkg::CSR_GAIN_I, psc_pkg::GAIN_I_RESET);
      write_csr(psc_pkg::CSR_GAIN_D, psc_pkg::GAIN_D_RESET);
      write_csr(psc_pkg::CSR_MAX_SPEED, 24'd65535);
      run_traffic(80);
      drain_responses();
   endtask

   initial begin
      cfg_gain_p = psc_pkg::GAIN_P_RESET;
      cfg_gain_i = psc_pkg::GAIN_I_RESET;
      cfg_gain_d = psc_pkg::GAIN_D_RESET;
      cfg_max_speed = psc_pkg::MAX_SPEED_RESET;
      loop_last_err = '0;
      loop_err_sum = '0;
      last_drive = '0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_target_speed <= '0;
      req_measured_speed <= '0;
      rsp_stall <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index <= psc_pkg::CSR_GAIN_P;
      csr_wdata <= '0;
      rsp_idle_on <= 1'b1;
      rsp_hold <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      req_idle_on = 1'b1;
      test_reset_defaults();
      test_gain_extremes();
      test_speed_limit();
      req_idle_on = 1'b0;
      test_integral_windup();
      test_backpressure();
      req_idle_on = 1'b1;
      test_random_traffic();

      // Let the pipeline settle, then report
      repeat (12) @(posedge clock);
      if (expected_cmds.size() != 0) begin
         $display("%0t: %0d expected responses never arrived", $time, expected_cmds.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
